FILE: src/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bit-level I2C master core.
// Used by the engine, the top level and the port checker; depends on nothing.
package i2cm_pkg;

    localparam int unsigned CFG_W     = 8;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] TICKS_PER_US_RST   = 8'd72;
    localparam logic [CFG_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

    typedef enum logic [0:0] {
        CFG_TICKS_PER_US   = 1'b0,
        CFG_ACK_POLL_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_START    = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_WRITE    = 3'd3,
        KIND_READ     = 3'd4,
        KIND_WAIT_ACK = 3'd5
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_SP_A = 5'd3,
        PH_SP_B = 5'd4,
        PH_WA_A = 5'd5,
        PH_WA_B = 5'd6,
        PH_POLL = 5'd7,
        PH_WR_A = 5'd8,
        PH_WR_B = 5'd9,
        PH_WR_C = 5'd10,
        PH_WR_D = 5'd11,
        PH_WR_E = 5'd12,
        PH_RD_A = 5'd13,
        PH_RD_B = 5'd14,
        PH_RD_C = 5'd15,
        PH_RD_D = 5'd16
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    // Packed so that scl_out lands in the lowest bit.
    typedef struct packed {
        logic       ack_error;
        logic [7:0] rd_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

FILE: src/i2c_bit_level_master_core.sv
`timescale 1ns / 1ps
// Top level of the bit-level I2C master: stream ports, configuration registers,
// input and result registers around i2cm_engine. Depends on i2cm_pkg.
//
//  Channel     Direction  Payload
//  s_axis      in         tuser: kind; tdata: wr_data, send_ack, sda_in
//  m_axis      out        tdata: scl, sda, drive, busy, done, rd_data, ack_error
//  cfg         in         i_cfg_idx selects the register, i_cfg_wdata the value
//
// One transaction is taken per cycle while the result channel does not stall;
// each passes the input and output registers, and steps the engine's state once.
// Reset is synchronous: both stages empty, line state idle with SCL and SDA high.
// A stalled result holds the output register; the input register takes new data
// only while it is empty or can move forward.
module i2c_bit_level_master_core
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // wr_data[7:0], send_ack[8], sda_in[9]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,  // kind[2:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // scl, sda, drive, busy, done,
                                                  // rd_data[12:5], ack_error[13]
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic             r_in_valid;
    t_item            r_in_item;
    logic             r_out_valid;
    t_result          r_out_data;
    logic [CFG_W-1:0] r_ticks_per_us;
    logic [CFG_W-1:0] r_ack_poll_limit;
    logic             advance;
    t_result          result;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us   <= TICKS_PER_US_RST;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICKS_PER_US:   r_ticks_per_us   <= i_cfg_wdata;
                CFG_ACK_POLL_LIMIT: r_ack_poll_limit <= i_cfg_wdata;
                default:            r_ticks_per_us   <= r_ticks_per_us;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item.kind     <= i_s_axis_tuser;
            r_in_item.wr_data  <= i_s_axis_tdata[7:0];
            r_in_item.send_ack <= i_s_axis_tdata[8];
            r_in_item.sda_in   <= i_s_axis_tdata[9];
        end
    end

    i2cm_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_item           (r_in_item),
        .i_ticks_per_us   (r_ticks_per_us),
        .i_ack_poll_limit (r_ack_poll_limit),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out_data};

endmodule

FILE: src/i2cm_engine.sv
`timescale 1ns / 1ps
// Bus sequencer: holds the line state and advances it by one tick per step.
// Depends on i2cm_pkg.
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_ticks_per_us,
    input  logic [CFG_W-1:0] i_ack_poll_limit,
    output t_result          o_result
);

    t_phase     r_phase,    n_phase;
    logic [2:0] r_cmd,      n_cmd;
    logic [3:0] r_bit_idx,  n_bit_idx;
    logic [7:0] r_shift,    n_shift;
    logic [7:0] r_prescale, n_prescale;
    logic [2:0] r_delay,    n_delay;
    logic [7:0] r_poll,     n_poll;
    logic       r_scl,      n_scl;
    logic       r_sda,      n_sda;
    logic       r_sda_en,   n_sda_en;
    logic       r_ack_sel,  n_ack_sel;
    logic [7:0] r_rd_hold,  n_rd_hold;
    logic       r_err,      n_err;
    logic       done_now;
    logic       do_expire;
    logic [7:0] tpu;

    assign tpu = (i_ticks_per_us == '0) ? 8'd1 : i_ticks_per_us;

    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_prescale = r_prescale;
        n_delay    = r_delay;
        n_poll     = r_poll;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_sda_en   = r_sda_en;
        n_ack_sel  = r_ack_sel;
        n_rd_hold  = r_rd_hold;
        n_err      = r_err;
        done_now   = 1'b0;
        do_expire  = 1'b0;

        if (r_phase == PH_IDLE) begin
            if ((i_item.kind >= KIND_START) && (i_item.kind <= KIND_WAIT_ACK)) begin
                n_err      = 1'b0;
                n_cmd      = i_item.kind;
                n_bit_idx  = '0;
                n_prescale = '0;
                case (i_item.kind)
                    KIND_START: begin
                        n_sda_en = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                        n_phase  = PH_ST_A;
                        n_delay  = 3'd4;
                    end
                    KIND_STOP: begin
                        n_sda_en = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP_A;
                        n_delay  = 3'd4;
                    end
                    KIND_WRITE: begin
                        n_sda_en = 1'b1;
                        n_shift  = i_item.wr_data;
                        n_phase  = PH_WR_A;
                        n_delay  = 3'd2;
                    end
                    KIND_READ: begin
                        n_sda_en  = 1'b0;
                        n_sda     = 1'b1;
                        n_shift   = '0;
                        n_ack_sel = i_item.send_ack;
                        n_scl     = 1'b0;
                        n_phase   = PH_RD_A;
                        n_delay   = 3'd2;
                    end
                    default: begin
                        n_sda_en = 1'b0;
                        n_sda    = 1'b1;
                        n_phase  = PH_WA_A;
                        n_delay  = 3'd1;
                    end
                endcase
            end
        end else if (r_phase == PH_POLL) begin
            if (!i_item.sda_in) begin
                n_scl    = 1'b0;
                n_phase  = PH_IDLE;
                n_cmd    = KIND_NONE;
                done_now = 1'b1;
            end else if (r_poll >= i_ack_poll_limit) begin
                n_sda_en   = 1'b1;
                n_scl      = 1'b0;
                n_sda      = 1'b0;
                n_phase    = PH_SP_A;
                n_delay    = 3'd4;
                n_prescale = '0;
            end else begin
                n_poll = r_poll + 8'd1;
            end
        end else begin
            if (r_delay == '0) begin
                do_expire = 1'b1;
            end else begin
                n_prescale = r_prescale + 8'd1;
                if (n_prescale >= tpu) begin
                    n_prescale = '0;
                    n_delay    = r_delay - 3'd1;
                    do_expire  = (n_delay == '0);
                end
            end

            if (do_expire) begin
                unique case (r_phase)
                    PH_ST_A: begin
                        n_sda      = 1'b0;
                        n_phase    = PH_ST_B;
                        n_delay    = 3'd4;
                        n_prescale = '0;
                    end
                    PH_ST_B: begin
                        n_scl    = 1'b0;
                        n_phase  = PH_IDLE;
                        n_cmd    = KIND_NONE;
                        done_now = 1'b1;
                    end
                    PH_SP_A: begin
                        n_scl      = 1'b1;
                        n_sda      = 1'b1;
                        n_phase    = PH_SP_B;
                        n_delay    = 3'd4;
                        n_prescale = '0;
                    end
                    PH_SP_B: begin
                        if (r_cmd == KIND_WAIT_ACK) begin
                            n_err = 1'b1;
                        end
                        n_phase  = PH_IDLE;
                        n_cmd    = KIND_NONE;
                        done_now = 1'b1;
                    end
                    PH_WA_A: begin
                        n_scl      = 1'b1;
                        n_phase    = PH_WA_B;
                        n_delay    = 3'd1;
                        n_prescale = '0;
                    end
                    PH_WA_B: begin
                        n_phase = PH_POLL;
                        n_poll  = '0;
                    end
                    PH_WR_A: begin
                        n_scl      = 1'b0;
                        n_phase    = PH_WR_B;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                    end
                    PH_WR_B: begin
                        n_sda      = r_shift[7];
                        n_shift    = {r_shift[6:0], 1'b0};
                        n_phase    = PH_WR_C;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                    end
                    PH_WR_C: begin
                        n_scl      = 1'b1;
                        n_phase    = PH_WR_D;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                    end
                    PH_WR_D: begin
                        n_scl      = 1'b0;
                        n_phase    = PH_WR_E;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                    end
                    PH_WR_E: begin
                        n_bit_idx = r_bit_idx + 4'd1;
                        if (n_bit_idx >= 4'd8) begin
                            n_phase  = PH_IDLE;
                            n_cmd    = KIND_NONE;
                            done_now = 1'b1;
                        end else begin
                            n_sda      = r_shift[7];
                            n_shift    = {r_shift[6:0], 1'b0};
                            n_phase    = PH_WR_C;
                            n_delay    = 3'd2;
                            n_prescale = '0;
                        end
                    end
                    PH_RD_A: begin
                        n_scl      = 1'b1;
                        n_shift    = {r_shift[6:0], i_item.sda_in};
                        n_phase    = PH_RD_B;
                        n_delay    = 3'd1;
                        n_prescale = '0;
                    end
                    PH_RD_B: begin
                        n_bit_idx  = r_bit_idx + 4'd1;
                        n_scl      = 1'b0;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                        if (n_bit_idx < 4'd8) begin
                            n_phase = PH_RD_A;
                        end else begin
                            n_sda_en = 1'b1;
                            n_sda    = ~r_ack_sel;
                            n_phase  = PH_RD_C;
                        end
                    end
                    PH_RD_C: begin
                        n_scl      = 1'b1;
                        n_phase    = PH_RD_D;
                        n_delay    = 3'd2;
                        n_prescale = '0;
                    end
                    PH_RD_D: begin
                        n_scl     = 1'b0;
                        n_rd_hold = r_shift;
                        n_phase   = PH_IDLE;
                        n_cmd     = KIND_NONE;
                        done_now  = 1'b1;
                    end
                    default: begin
                        n_phase  = PH_IDLE;
                        n_cmd    = KIND_NONE;
                        done_now = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.sda_drive = n_sda_en;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done_now;
        o_result.rd_data   = n_rd_hold;
        o_result.ack_error = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cmd      <= KIND_NONE;
            r_bit_idx  <= '0;
            r_shift    <= '0;
            r_prescale <= '0;
            r_delay    <= '0;
            r_poll     <= '0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_sda_en   <= 1'b1;
            r_ack_sel  <= 1'b0;
            r_rd_hold  <= '0;
            r_err      <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_cmd      <= n_cmd;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_prescale <= n_prescale;
            r_delay    <= n_delay;
            r_poll     <= n_poll;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_sda_en   <= n_sda_en;
            r_ack_sel  <= n_ack_sel;
            r_rd_hold  <= n_rd_hold;
            r_err      <= n_err;
        end
    end

endmodule

FILE: src/i2cm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the bit-level I2C master, bound to the top level.
// Depends on i2cm_pkg.
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic m_busy;
    logic m_done;
    logic m_err;
    logic m_sda;
    logic m_drive;

    assign m_busy  = o_m_axis_tdata[3];
    assign m_done  = o_m_axis_tdata[4];
    assign m_err   = o_m_axis_tdata[13];
    assign m_sda   = o_m_axis_tdata[1];
    assign m_drive = o_m_axis_tdata[2];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result channel valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled transaction changed or vanished");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_done |-> !m_busy)
        else $error("command finished but core still busy");

    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_err |-> !m_busy)
        else $error("ack error shown while a command runs");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !m_drive |-> m_sda)
        else $error("SDA released with a low output level");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
